// ===== rtl/twa_pkg.sv =====
// Shared types, constants and helpers for the thruster wrench allocation block.
package twa_pkg;

    localparam int AXES            = 6;
    localparam int WORD_W          = 16;
    localparam int LIMIT_W         = 15;
    localparam int MOTOR_W         = 3;
    localparam int COUNT_W         = 4;
    localparam int AXIS_W          = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int PROD_W          = 2 * WORD_W;
    localparam int PAIR_W          = PROD_W + 1;
    localparam int ACC_W           = PROD_W + 3;
    localparam int THRUST_W        = 21;
    localparam int ROUND_SHIFT     = 14;
    localparam int RESULT_CAP      = 8;
    localparam int DEF_MAX_MOTORS  = 8;
    localparam int ROW_CMP_W       = 5;

    localparam logic [LIMIT_W-1:0] FORCE_LIM_RST   = 15'd15360;
    localparam logic [LIMIT_W-1:0] TORQUE_LIM_RST  = 15'd20480;
    localparam logic [COUNT_W-1:0] MOTOR_COUNT_RST = 4'd8;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(8192);
    localparam logic signed [ACC_W-1:0] THRUST_HI  = ACC_W'(1048575);
    localparam logic signed [ACC_W-1:0] THRUST_LO  = -ACC_W'(1048576);

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_WRENCH = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORCE_LIM   = 2'd0,
        CFG_TORQUE_LIM  = 2'd1,
        CFG_MOTOR_COUNT = 2'd2
    } cfg_idx_t;

    // Six 16-bit lanes, one per axis: surge, sway, heave, roll, pitch, yaw.
    typedef logic [AXES-1:0][WORD_W-1:0] vec_t;

    typedef struct packed {
        logic               valid;
        logic [MOTOR_W-1:0] motor;
        logic               last;
    } row_tag_t;

    function automatic logic [WORD_W-1:0] clamp_sym(
        input logic signed [WORD_W-1:0] v,
        input logic [LIMIT_W-1:0]       lim
    );
        logic signed [WORD_W-1:0] hi;
        logic signed [WORD_W-1:0] lo;
        hi = $signed({1'b0, lim});
        lo = -hi;
        if (v > hi)
            return hi;
        else if (v < lo)
            return lo;
        else
            return v;
    endfunction

endpackage

// ===== rtl/twa_table.sv =====
// Allocation coefficient table: per-coefficient writes, one registered motor row read per cycle while rd_en is high.
module twa_table #(
    parameter int MAX_MOTORS = twa_pkg::DEF_MAX_MOTORS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [twa_pkg::MOTOR_W-1:0]   wr_motor,
    input  logic [twa_pkg::AXIS_W-1:0]    wr_axis,
    input  logic [twa_pkg::WORD_W-1:0]    wr_data,
    input  logic                          rd_en,
    input  logic [twa_pkg::MOTOR_W-1:0]   rd_motor,
    output twa_pkg::vec_t                 rd_row_reg
);

    twa_pkg::vec_t coef_reg [MAX_MOTORS];
    twa_pkg::vec_t rd_row_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < MAX_MOTORS; r++)
                coef_reg[r] <= '0;
        end else if (wr_en) begin
            // out-of-range motor or axis matches no entry, so nothing changes
            for (int r = 0; r < MAX_MOTORS; r++) begin
                for (int a = 0; a < twa_pkg::AXES; a++) begin
                    if (twa_pkg::ROW_CMP_W'(r) == twa_pkg::ROW_CMP_W'(wr_motor) &&
                        twa_pkg::AXIS_W'(a) == wr_axis)
                        coef_reg[r][a] <= wr_data;
                end
            end
        end
    end

    always_comb begin
        rd_row_next = '0;
        for (int r = 0; r < MAX_MOTORS; r++) begin
            if (twa_pkg::ROW_CMP_W'(r) == twa_pkg::ROW_CMP_W'(rd_motor))
                rd_row_next = coef_reg[r];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en)
            rd_row_reg <= rd_row_next;
    end

endmodule

// ===== rtl/twa_datapath.sv =====
// Dot-product pipeline: multiply, pair sums, final sum with rounding and saturation.
module twa_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  twa_pkg::row_tag_t               tag_in,
    input  twa_pkg::vec_t                   wrench_in,
    input  twa_pkg::vec_t                   coef_row,
    output logic                            advance,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [twa_pkg::MOTOR_W-1:0]     m_motor_number,
    output logic signed [twa_pkg::THRUST_W-1:0] m_thrust,
    output logic                            m_last_motor
);

    twa_pkg::row_tag_t s1_tag_reg, s2_tag_reg, s3_tag_reg;
    twa_pkg::vec_t     s1_wrench_reg;

    logic signed [twa_pkg::PROD_W-1:0] prod_reg [twa_pkg::AXES];
    logic signed [twa_pkg::PAIR_W-1:0] pair_reg [twa_pkg::AXES/2];

    logic signed [twa_pkg::ACC_W-1:0]    acc;
    logic signed [twa_pkg::ACC_W-1:0]    shifted;
    logic signed [twa_pkg::THRUST_W-1:0] thrust_next;

    logic                               out_valid_reg;
    logic [twa_pkg::MOTOR_W-1:0]        out_motor_reg;
    logic signed [twa_pkg::THRUST_W-1:0] out_thrust_reg;
    logic                               out_last_reg;

    // whole pipe moves together; it holds only while a word waits at the output
    assign advance = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg    <= '0;
            s2_tag_reg    <= '0;
            s3_tag_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_tag_reg    <= tag_in;
            s2_tag_reg    <= s1_tag_reg;
            s3_tag_reg    <= s2_tag_reg;
            out_valid_reg <= s3_tag_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_wrench_reg <= wrench_in;
            for (int a = 0; a < twa_pkg::AXES; a++)
                prod_reg[a] <= $signed(s1_wrench_reg[a]) * $signed(coef_row[a]);
            for (int p = 0; p < twa_pkg::AXES/2; p++)
                pair_reg[p] <= twa_pkg::PAIR_W'(prod_reg[2*p]) +
                               twa_pkg::PAIR_W'(prod_reg[2*p+1]);
            out_motor_reg  <= s3_tag_reg.motor;
            out_last_reg   <= s3_tag_reg.last;
            out_thrust_reg <= thrust_next;
        end
    end

    // Q10.22 product sum to Q13.8: round half up, then clip to the thrust range
    always_comb begin
        acc = twa_pkg::ACC_W'(pair_reg[0]) + twa_pkg::ACC_W'(pair_reg[1]) +
              twa_pkg::ACC_W'(pair_reg[2]) + twa_pkg::ROUND_BIAS;
        shifted = acc >>> twa_pkg::ROUND_SHIFT;
        if (shifted > twa_pkg::THRUST_HI)
            thrust_next = twa_pkg::THRUST_HI[twa_pkg::THRUST_W-1:0];
        else if (shifted < twa_pkg::THRUST_LO)
            thrust_next = twa_pkg::THRUST_LO[twa_pkg::THRUST_W-1:0];
        else
            thrust_next = shifted[twa_pkg::THRUST_W-1:0];
    end

    assign m_valid        = out_valid_reg;
    assign m_motor_number = out_motor_reg;
    assign m_thrust       = out_thrust_reg;
    assign m_last_motor   = out_last_reg;

endmodule

// ===== rtl/thruster_wrench_allocation_unit.sv =====
// Top level of the thruster wrench allocation block: input control, row sequencer, config.
//
// Input words (s_valid/s_ready) either load one table coefficient (s_command = load)
// or apply a wrench (s_command = wrench). Forces and torques are clamped on entry,
// then one motor row per cycle is sent, unless stalled, down a four-register pipeline:
// coefficient read, six multiplies, pair sums, final sum with round and saturate.
// Each wrench gives one output word (m_valid/m_ready) per motor in use, in motor
// order, with m_last_motor set on the final one; a load gives no output word.
// A wrench holds the input until the last of its n rows issues, n = min(motor_count,
// MAX_MOTORS, 8), and the next word may enter as that row issues; a load or a wrench
// with n = 0 does not hold the input. The row sequencer issues one table row per cycle
// while the pipeline advances.
// When the receiver stalls, the whole pipeline holds and s_ready drops once the
// sequencer cannot move; nothing is lost or repeated.
// Reset (aresetn low, synchronous) zeroes the table, restores the force limit to
// 60.0, the torque limit to 80.0, motor_count to 8 and empties the pipeline.
// Configuration writes (cfg_wr_en) take effect at once; the user must make them while idle (not enforced).
module thruster_wrench_allocation_unit #(
    parameter int MAX_MOTORS = twa_pkg::DEF_MAX_MOTORS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [twa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [twa_pkg::LIMIT_W-1:0]         cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [twa_pkg::MOTOR_W-1:0]         s_motor_index,
    input  logic [twa_pkg::AXIS_W-1:0]          s_axis_index,
    input  logic signed [twa_pkg::WORD_W-1:0]   s_coefficient,
    input  logic signed [twa_pkg::WORD_W-1:0]   s_force_x,
    input  logic signed [twa_pkg::WORD_W-1:0]   s_force_y,
    input  logic signed [twa_pkg::WORD_W-1:0]   s_force_z,
    input  logic signed [twa_pkg::WORD_W-1:0]   s_torque_x,
    input  logic signed [twa_pkg::WORD_W-1:0]   s_torque_y,
    input  logic signed [twa_pkg::WORD_W-1:0]   s_torque_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [twa_pkg::MOTOR_W-1:0]         m_motor_number,
    output logic signed [twa_pkg::THRUST_W-1:0] m_thrust,
    output logic                                m_last_motor
);

    localparam int CAP = (MAX_MOTORS < twa_pkg::RESULT_CAP) ? MAX_MOTORS
                                                             : twa_pkg::RESULT_CAP;

    logic [twa_pkg::LIMIT_W-1:0] force_lim_reg;
    logic [twa_pkg::LIMIT_W-1:0] torque_lim_reg;
    logic [twa_pkg::COUNT_W-1:0] motor_count_reg;

    logic                         busy_reg;
    logic [twa_pkg::MOTOR_W-1:0]  cnt_reg;
    logic [twa_pkg::COUNT_W-1:0]  n_reg;
    twa_pkg::vec_t                wrench_reg;

    twa_pkg::vec_t                wrench_next;
    logic [twa_pkg::COUNT_W-1:0]  n_next;
    logic                         advance;
    logic                         last_issue;
    logic                         accept;
    logic                         is_wrench;
    twa_pkg::row_tag_t            tag;
    twa_pkg::vec_t                coef_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            force_lim_reg   <= twa_pkg::FORCE_LIM_RST;
            torque_lim_reg  <= twa_pkg::TORQUE_LIM_RST;
            motor_count_reg <= twa_pkg::MOTOR_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (twa_pkg::cfg_idx_t'(cfg_index))
                twa_pkg::CFG_FORCE_LIM:   force_lim_reg   <= cfg_wdata;
                twa_pkg::CFG_TORQUE_LIM:  torque_lim_reg  <= cfg_wdata;
                twa_pkg::CFG_MOTOR_COUNT: motor_count_reg <= cfg_wdata[twa_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign last_issue = ({1'b0, cnt_reg} + twa_pkg::COUNT_W'(1)) == n_reg;
    // next word may enter on the edge that issues the final row
    assign s_ready    = !busy_reg || (advance && last_issue);
    assign accept     = s_valid && s_ready;
    assign is_wrench  = (twa_pkg::cmd_t'(s_command) == twa_pkg::CMD_WRENCH);

    always_comb begin
        wrench_next[0] = twa_pkg::clamp_sym(s_force_x,  force_lim_reg);
        wrench_next[1] = twa_pkg::clamp_sym(s_force_y,  force_lim_reg);
        wrench_next[2] = twa_pkg::clamp_sym(s_force_z,  force_lim_reg);
        wrench_next[3] = twa_pkg::clamp_sym(s_torque_x, torque_lim_reg);
        wrench_next[4] = twa_pkg::clamp_sym(s_torque_y, torque_lim_reg);
        wrench_next[5] = twa_pkg::clamp_sym(s_torque_z, torque_lim_reg);
        if (motor_count_reg > twa_pkg::COUNT_W'(CAP))
            n_next = twa_pkg::COUNT_W'(CAP);
        else
            n_next = motor_count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            n_reg    <= '0;
        end else if (accept && is_wrench && n_next != '0) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            n_reg    <= n_next;
        end else if (busy_reg && advance) begin
            if (last_issue)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + twa_pkg::MOTOR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_wrench)
            wrench_reg <= wrench_next;
    end

    assign tag.valid = busy_reg;
    assign tag.motor = cnt_reg;
    assign tag.last  = last_issue;

    twa_table #(
        .MAX_MOTORS(MAX_MOTORS)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (accept && !is_wrench),
        .wr_motor   (s_motor_index),
        .wr_axis    (s_axis_index),
        .wr_data    (s_coefficient),
        .rd_en      (advance),
        .rd_motor   (cnt_reg),
        .rd_row_reg (coef_row)
    );

    twa_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .tag_in         (tag),
        .wrench_in      (wrench_reg),
        .coef_row       (coef_row),
        .advance        (advance),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_motor_number (m_motor_number),
        .m_thrust       (m_thrust),
        .m_last_motor   (m_last_motor)
    );

endmodule
